>>> design/bba_pkg.sv
// Shared types and constants for the bit buffer with append and field extract.
package bba_pkg;

   localparam int LEN_W      = 13;
   localparam int FIELD_BITS = 32;
   localparam int SHIFT_W    = $clog2(FIELD_BITS);
   localparam int TOT_W      = $clog2(FIELD_BITS + 1);

   typedef enum logic [2:0] {
      OP_APPEND     = 3'd0,
      OP_SET_BIT    = 3'd1,
      OP_GET_BIT    = 3'd2,
      OP_GET_RANGE  = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_SET_LENGTH = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_DONE
   } state_type;

   // Selects a run of bits from one stored byte and places it in the field.
   typedef struct packed {
      logic [2:0]         offset;
      logic [3:0]         count;
      logic [SHIFT_W-1:0] shift;
   } merge_ctl_type;

endpackage

>>> design/bba_store.sv
// Byte store: one write port and one registered read port.
module bba_store
   #(parameter int DEPTH  = 512,
     parameter int ADDR_W = 9)
   (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
   );

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bba_merge.sv
// Bit gather unit: reorders one byte by read order and places a run of its bits.
module bba_merge
   import bba_pkg::*;
   (
   input  logic                  bit_order,
   input  logic [7:0]            byte_data,
   input  merge_ctl_type         ctl,
   output logic [FIELD_BITS-1:0] contrib
   );

   logic [7:0] ordered;
   logic [8:0] mask9;
   logic [7:0] chunk;

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         ordered[j] = bit_order ? byte_data[7-j] : byte_data[j];
      end
   end

   assign mask9   = (9'd1 << ctl.count) - 9'd1;
   assign chunk   = (ordered >> ctl.offset) & mask9[7:0];
   assign contrib = FIELD_BITS'(chunk) << ctl.shift;

endmodule

>>> design/bit_buffer_append_extract.sv
// Top level: sequencer, length counters and result register of the bit buffer.
//
//   channel   direction  handshake                      payload
//   req_      in         req_valid / req_ready          op, bit_value, index, end_index,
//                                                       first_is_msb, new_length
//   rsp_      out        rsp_valid / rsp_ready          read_value, length, status
//   csr_      in         csr_write_enable (no wait)     bit_order
//
// Items go from idle straight to the done state (clear, set length, rejected ops, appends into a
// fresh byte), or through the merge state (get bit, set bit, other appends: the byte store has one
// registered read port); a range read stays in the merge state for each stored byte it spans (at most 5),
// one byte per cycle through the gather unit. The result register is loaded in the done state.
// Reset is synchronous and clears the counters, control and bit_order, not the byte store.
// Requests are taken only when idle; a result waiting on rsp_ready holds the next item in
// its last cycle.
module bit_buffer_append_extract
   import bba_pkg::*;
   #(parameter int STORE_BYTES = 512)
   (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_op,
   input  logic                  req_bit_value,
   input  logic [12:0]           req_index,
   input  logic [12:0]           req_end_index,
   input  logic                  req_first_is_msb,
   input  logic [12:0]           req_new_length,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FIELD_BITS-1:0] rsp_read_value,
   output logic [LEN_W-1:0]      rsp_length,
   output logic                  rsp_status,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
   );

   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int AL_W   = $clog2(STORE_BYTES + 1);
   localparam int CNT_W  = AL_W + 3;
   localparam int W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic                  val_ff, val_in;
   logic                  pack_ff, pack_in;
   logic                  st_ff, st_in;
   logic [W-1:0]          lo_ff, lo_in;
   logic [W-1:0]          hi_ff, hi_in;
   logic [W-1:0]          cur_ff, cur_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]      bit_count_ff, bit_count_in;
   logic [AL_W-1:0]       alloc_ff, alloc_in;
   logic                  bit_order_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [LEN_W-1:0]      rsp_length_ff, rsp_length_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic                  mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]     mem_wr_addr, mem_rd_addr;
   logic [7:0]            mem_wr_data, mem_rd_data;
   merge_ctl_type         merge_ctl;
   logic [FIELD_BITS-1:0] contrib;

   logic [W-1:0]          idx_w, end_w, nlen_w, cnt_w, alloc_bits, span;
   logic                  alloc_full, span_long;
   logic [W-1:0]          rng_rem, rng_next;
   logic [3:0]            rng_room, rng_n;
   logic [7:0]            bit_mask, byte_upd;
   logic [TOT_W-1:0]      tot;
   logic [FIELD_BITS-1:0] rev_acc, packed_val;

   bba_store #(.DEPTH(STORE_BYTES), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bba_merge u_merge (
      .bit_order (bit_order_ff),
      .byte_data (mem_rd_data),
      .ctl       (merge_ctl),
      .contrib   (contrib)
   );

   assign idx_w      = W'(req_index);
   assign end_w      = W'(req_end_index);
   assign nlen_w     = W'(req_new_length);
   assign cnt_w      = W'(bit_count_ff);
   assign alloc_bits = W'({alloc_ff, 3'b000});
   assign alloc_full = (alloc_ff == AL_W'(STORE_BYTES));
   assign span       = end_w - idx_w;
   assign span_long  = (span > W'(FIELD_BITS));

   // Run of bits taken from the current byte of a range read
   assign rng_rem  = hi_ff - cur_ff;
   assign rng_room = 4'd8 - {1'b0, cur_ff[2:0]};
   assign rng_n    = (rng_rem < W'(rng_room)) ? rng_rem[3:0] : rng_room;
   assign rng_next = cur_ff + W'(rng_n);

   assign bit_mask = 8'd1 << cur_ff[2:0];
   assign byte_upd = val_ff ? (mem_rd_data | bit_mask) : (mem_rd_data & ~bit_mask);

   // First bit as MSB: mirror the gathered field and drop the unused low end
   assign tot = TOT_W'(hi_ff - lo_ff);
   always_comb begin
      for (int j = 0; j < FIELD_BITS; j++) begin
         rev_acc[j] = acc_ff[FIELD_BITS-1-j];
      end
   end
   assign packed_val = rev_acc >> (TOT_W'(FIELD_BITS) - tot);

   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      val_in             = val_ff;
      pack_in            = pack_ff;
      st_in              = st_ff;
      lo_in              = lo_ff;
      hi_in              = hi_ff;
      cur_in             = cur_ff;
      acc_in             = acc_ff;
      bit_count_in       = bit_count_ff;
      alloc_in           = alloc_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_length_in      = rsp_length_ff;
      rsp_status_in      = rsp_status_ff;
      mem_wr_en          = 1'b0;
      mem_wr_addr        = '0;
      mem_wr_data        = '0;
      mem_rd_en          = 1'b0;
      mem_rd_addr        = '0;
      merge_ctl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_op);
               val_in   = req_bit_value;
               acc_in   = '0;
               st_in    = 1'b0;
               pack_in  = 1'b0;
               state_in = ST_DONE;
               unique case (op_type'(req_op))
                  OP_APPEND: begin
                     if (cnt_w == alloc_bits) begin
                        if (alloc_full) begin
                           st_in = 1'b1;
                        end else begin
                           // fresh byte: zero it with the new bit in place
                           mem_wr_en    = 1'b1;
                           mem_wr_addr  = ADDR_W'(alloc_ff);
                           mem_wr_data  = {7'b0, req_bit_value};
                           alloc_in     = alloc_ff + AL_W'(1);
                           bit_count_in = bit_count_ff + CNT_W'(1);
                        end
                     end else begin
                        cur_in      = cnt_w;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ADDR_W'(cnt_w >> 3);
                        state_in    = ST_MERGE;
                     end
                  end
                  OP_SET_BIT, OP_GET_BIT: begin
                     if (idx_w >= cnt_w) begin
                        st_in = 1'b1;
                     end else begin
                        cur_in      = idx_w;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ADDR_W'(idx_w >> 3);
                        state_in    = ST_MERGE;
                     end
                  end
                  OP_GET_RANGE: begin
                     if (idx_w > cnt_w || end_w > cnt_w) begin
                        st_in = 1'b1;
                     end else if (end_w > idx_w) begin
                        pack_in = req_first_is_msb;
                        if (req_first_is_msb) begin
                           lo_in = span_long ? (end_w - W'(FIELD_BITS)) : idx_w;
                           hi_in = end_w;
                        end else begin
                           lo_in = idx_w;
                           hi_in = span_long ? (idx_w + W'(FIELD_BITS)) : end_w;
                        end
                        cur_in      = lo_in;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ADDR_W'(lo_in >> 3);
                        state_in    = ST_MERGE;
                     end
                  end
                  OP_CLEAR: begin
                     bit_count_in = '0;
                     alloc_in     = '0;
                  end
                  OP_SET_LENGTH: begin
                     if (nlen_w > alloc_bits) begin
                        bit_count_in = CNT_W'(alloc_bits);
                     end else begin
                        bit_count_in = CNT_W'(nlen_w);
                     end
                  end
                  default: begin
                     st_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MERGE: begin
            case (op_ff)
               OP_GET_RANGE: begin
                  merge_ctl.offset = cur_ff[2:0];
                  merge_ctl.count  = rng_n;
                  merge_ctl.shift  = SHIFT_W'(cur_ff - lo_ff);
                  acc_in           = acc_ff | contrib;
                  cur_in           = rng_next;
                  if (rng_next < hi_ff) begin
                     // fetch the next byte while this one is merged
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ADDR_W'(rng_next >> 3);
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               OP_GET_BIT: begin
                  merge_ctl.offset = cur_ff[2:0];
                  merge_ctl.count  = 4'd1;
                  acc_in           = contrib;
                  state_in         = ST_DONE;
               end
               OP_APPEND: begin
                  mem_wr_en    = 1'b1;
                  mem_wr_addr  = ADDR_W'(cur_ff >> 3);
                  mem_wr_data  = byte_upd;
                  bit_count_in = bit_count_ff + CNT_W'(1);
                  state_in     = ST_DONE;
               end
               default: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = ADDR_W'(cur_ff >> 3);
                  mem_wr_data = byte_upd;
                  state_in    = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = pack_ff ? packed_val : acc_ff;
               rsp_length_in     = cnt_w[LEN_W-1:0];
               rsp_status_in     = st_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_count_ff <= '0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_count_ff <= bit_count_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_order_ff <= 1'b0;
      end else if (csr_write_enable) begin
         bit_order_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      val_ff            <= val_in;
      pack_ff           <= pack_in;
      st_ff             <= st_in;
      lo_ff             <= lo_in;
      hi_ff             <= hi_in;
      cur_ff            <= cur_in;
      acc_ff            <= acc_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_length_ff     <= rsp_length_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the bit buffer: directed rows, a full-store pass and random phases.
`timescale 1ns / 1ps

module testbench
   import bba_pkg::*;
   ();

   localparam int STORE_BYTES = 512;
   localparam int MAX_BITS    = STORE_BYTES * 8;
   localparam int IDLE_LIMIT  = 3000;
   localparam int PRINT_LIMIT = 50;
   localparam int PHASE_ITEMS = 35;

   localparam logic [2:0] OP_RESERVED_A = 3'd6;
   localparam logic [2:0] OP_RESERVED_B = 3'd7;
   localparam logic STAT_DONE    = 1'b0;
   localparam logic STAT_IGNORED = 1'b1;

   localparam logic [8:0] DIRECTED_BITS = 9'b1_0100_1101;

   typedef struct packed {
      logic [2:0]  op;
      logic        bit_value;
      logic [12:0] index;
      logic [12:0] end_index;
      logic        first_is_msb;
      logic [12:0] new_length;
   } request_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] value;
      logic [LEN_W-1:0]      length;
      logic                  status;
   } result_type;

   typedef struct packed {
      request_type rq;
      logic        typed;
      result_type  want;
   } directed_row_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_op           = '0;
   logic                  req_bit_value    = 1'b0;
   logic [12:0]           req_index        = '0;
   logic [12:0]           req_end_index    = '0;
   logic                  req_first_is_msb = 1'b0;
   logic [12:0]           req_new_length   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [FIELD_BITS-1:0] rsp_read_value;
   logic [LEN_W-1:0]      rsp_length;
   logic                  rsp_status;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data   = 1'b0;

   // Shadow copy of the buffer
   logic [7:0]  shadow_bytes [STORE_BYTES];
   int unsigned fill_bits   = 0;
   int unsigned alloc_bytes = 0;
   logic        read_order  = 1'b0;

   result_type       due_results [$];
   directed_row_type directed_rows [$];
   result_type       head_result;
   int               mismatch_count = 0;
   int               idle_cycles    = 0;
   int unsigned      rx_stall_left  = 0;
   bit               tx_eager       = 1'b0;
   bit               rx_eager       = 1'b0;

   bit_buffer_append_extract #(.STORE_BYTES(STORE_BYTES)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_bit_value    (req_bit_value),
      .req_index        (req_index),
      .req_end_index    (req_end_index),
      .req_first_is_msb (req_first_is_msb),
      .req_new_length   (req_new_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_length       (rsp_length),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic logic shadow_bit(int unsigned pos);
      logic [7:0]  b;
      int unsigned sh;
      b  = shadow_bytes[(pos / 8) % STORE_BYTES];
      sh = read_order ? 7 - (pos % 8) : pos % 8;
      return b[sh];
   endfunction

   // Writes always go LSB-first within the byte, whatever the read order
   function automatic void shadow_write(int unsigned pos, logic v);
      shadow_bytes[(pos / 8) % STORE_BYTES][pos % 8] = v;
   endfunction

   function automatic result_type predict_buffer_op(request_type rq);
      result_type  res;
      int unsigned ix;
      int unsigned ex;
      int unsigned b;
      int unsigned i;
      res = '0;
      ix  = 32'(rq.index);
      ex  = 32'(rq.end_index);
      case (rq.op)
         OP_APPEND: begin
            b = fill_bits / 8;
            if (b >= alloc_bytes && (alloc_bytes >= STORE_BYTES || b >= STORE_BYTES)) begin
               res.status = STAT_IGNORED;
            end else begin
               // a fresh byte starts out zeroed
               if (b >= alloc_bytes) begin
                  shadow_bytes[alloc_bytes] = '0;
                  alloc_bytes++;
               end
               shadow_write(fill_bits, rq.bit_value);
               fill_bits++;
            end
         end
         OP_SET_BIT: begin
            if (ix >= fill_bits) res.status = STAT_IGNORED;
            else shadow_write(ix, rq.bit_value);
         end
         OP_GET_BIT: begin
            if (ix >= fill_bits) res.status = STAT_IGNORED;
            else res.value = {{(FIELD_BITS-1){1'b0}}, shadow_bit(ix)};
         end
         OP_GET_RANGE: begin
            if (ix > fill_bits || ex > fill_bits) begin
               res.status = STAT_IGNORED;
            end else begin
               // MSB-first keeps the last bits read, LSB-first the first ones
               for (i = ix; i < ex; i++) begin
                  if (rq.first_is_msb) res.value = {res.value[FIELD_BITS-2:0], shadow_bit(i)};
                  else if (i - ix < FIELD_BITS) res.value[i - ix] = shadow_bit(i);
               end
            end
         end
         OP_CLEAR: begin
            fill_bits   = 0;
            alloc_bytes = 0;
         end
         OP_SET_LENGTH: begin
            if (32'(rq.new_length) > alloc_bytes * 8) fill_bits = alloc_bytes * 8;
            else fill_bits = 32'(rq.new_length);
         end
         default: res.status = STAT_IGNORED;
      endcase
      res.length = fill_bits[12:0];
      return res;
   endfunction

   function automatic request_type make_request(logic [2:0] op, logic v, int unsigned ix,
                                                int unsigned ex, logic msb,
                                                int unsigned nlen);
      request_type rq;
      rq.op           = op;
      rq.bit_value    = v;
      rq.index        = ix[12:0];
      rq.end_index    = ex[12:0];
      rq.first_is_msb = msb;
      rq.new_length   = nlen[12:0];
      return rq;
   endfunction

   // Mostly in-range accesses on the current contents, with some noise
   function automatic request_type random_request();
      request_type rq;
      int unsigned r;
      int unsigned span;
      int unsigned top;
      rq = make_request(OP_APPEND, 1'($urandom_range(0, 1)), $urandom_range(0, MAX_BITS),
                        $urandom_range(0, MAX_BITS), 1'($urandom_range(0, 1)),
                        $urandom_range(0, MAX_BITS));
      r = $urandom_range(0, 99);
      if (r < 30) begin
         rq.op = OP_APPEND;
      end else if (r < 57) begin
         rq.op = (r < 42) ? OP_SET_BIT : OP_GET_BIT;
         if (fill_bits != 0 && $urandom_range(0, 99) < 85)
            rq.index = 13'($urandom_range(0, fill_bits - 1));
      end else if (r < 82) begin
         rq.op = OP_GET_RANGE;
         r = $urandom_range(0, 9);
         if (r < 8) begin
            rq.index = 13'($urandom_range(0, fill_bits));
            span     = $urandom_range(0, 40);
            rq.end_index = 13'((32'(rq.index) + span > fill_bits) ?
                               fill_bits : 32'(rq.index) + span);
         end else if (r == 8) begin
            rq.index     = 13'($urandom_range(0, fill_bits));
            rq.end_index = 13'($urandom_range(0, 32'(rq.index)));
         end
      end else if (r < 85) begin
         rq.op = OP_CLEAR;
      end else if (r < 96) begin
         rq.op = OP_SET_LENGTH;
         top   = (alloc_bytes * 8 + 8 > MAX_BITS) ? MAX_BITS : alloc_bytes * 8 + 8;
         if ($urandom_range(0, 3) != 0) rq.new_length = 13'($urandom_range(0, top));
      end else begin
         rq.op = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
      end
      return rq;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   // Call at a rising edge; returns at the edge of the transfer
   task automatic issue(input request_type rq, input logic given, input result_type want);
      int unsigned gap;
      result_type  predicted;
      gap = tx_eager ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= rq.op;
      req_bit_value    <= rq.bit_value;
      req_index        <= rq.index;
      req_end_index    <= rq.end_index;
      req_first_is_msb <= rq.first_is_msb;
      req_new_length   <= rq.new_length;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = predict_buffer_op(rq);
      due_results.insert(due_results.size(), given ? want : predicted);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_bit_order(input logic order);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= order;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      read_order = order;
   endtask

   task automatic add_row(input request_type rq, input logic typed, input int unsigned len,
                          input logic st);
      directed_row_type row;
      row.rq   = rq;
      row.typed = typed;
      row.want = {{FIELD_BITS{1'b0}}, len[12:0], st};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Receiver: random stalls, none while rx_eager is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
         rsp_ready <= 1'b0;
         rx_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!rx_eager) rx_stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            report_mismatch("result with nothing due, read_value", '0, rsp_read_value);
         end else begin
            head_result = due_results.pop_front();
            if (rsp_read_value !== head_result.value)
               report_mismatch("read_value", head_result.value, rsp_read_value);
            if (rsp_length !== head_result.length)
               report_mismatch("length", 32'(head_result.length), 32'(rsp_length));
            if (rsp_status !== head_result.status)
               report_mismatch("status", 32'(head_result.status), 32'(rsp_status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int          k;
      int          n;
      int          phase;
      request_type rq;

      // Empty buffer, reserved ops, clamp on an empty store
      add_row(make_request(OP_GET_BIT, 1'b0, 0, 0, 1'b0, 0), 1'b1, 0, STAT_IGNORED);
      add_row(make_request(OP_GET_RANGE, 1'b0, 0, 0, 1'b1, 0), 1'b1, 0, STAT_DONE);
      add_row(make_request(OP_SET_BIT, 1'b1, 0, 0, 1'b0, 0), 1'b1, 0, STAT_IGNORED);
      add_row(make_request(OP_RESERVED_A, 1'b1, 0, 0, 1'b0, 0), 1'b1, 0, STAT_IGNORED);
      add_row(make_request(OP_RESERVED_B, 1'b0, MAX_BITS, MAX_BITS, 1'b1, MAX_BITS),
              1'b1, 0, STAT_IGNORED);
      add_row(make_request(OP_SET_LENGTH, 1'b0, 0, 0, 1'b0, MAX_BITS), 1'b1, 0, STAT_DONE);
      for (k = 0; k < 9; k++)
         add_row(make_request(OP_APPEND, DIRECTED_BITS[k], 0, 0, 1'b0, 0), 1'b1, k + 1,
                 STAT_DONE);
      add_row(make_request(OP_GET_BIT, 1'b0, 8, 0, 1'b0, 0), 1'b0, 0, STAT_DONE);
      add_row(make_request(OP_GET_BIT, 1'b0, 9, 0, 1'b0, 0), 1'b1, 9, STAT_IGNORED);
      add_row(make_request(OP_GET_RANGE, 1'b0, 0, 9, 1'b1, 0), 1'b0, 0, STAT_DONE);
      add_row(make_request(OP_GET_RANGE, 1'b0, 0, 9, 1'b0, 0), 1'b0, 0, STAT_DONE);
      add_row(make_request(OP_GET_RANGE, 1'b0, 2, 10, 1'b1, 0), 1'b1, 9, STAT_IGNORED);
      add_row(make_request(OP_GET_RANGE, 1'b0, 7, 2, 1'b0, 0), 1'b1, 9, STAT_DONE);
      add_row(make_request(OP_SET_BIT, 1'b1, 4, 0, 1'b0, 0), 1'b1, 9, STAT_DONE);
      // shorten, then append below the allocated end
      add_row(make_request(OP_SET_LENGTH, 1'b0, 0, 0, 1'b0, 3), 1'b1, 3, STAT_DONE);
      add_row(make_request(OP_APPEND, 1'b1, 0, 0, 1'b0, 0), 1'b1, 4, STAT_DONE);
      add_row(make_request(OP_CLEAR, 1'b0, 0, 0, 1'b0, 0), 1'b1, 0, STAT_DONE);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_bit_order(1'b0);
      for (n = 0; n < directed_rows.size(); n++)
         issue(directed_rows[n].rq, directed_rows[n].typed, directed_rows[n].want);

      // Fill the whole store a byte at a time: first bit, then stretch the length over it
      set_bit_order(1'b1);
      issue(make_request(OP_CLEAR, 1'b0, 0, 0, 1'b0, 0), 1'b0, '0);
      for (k = 0; k < STORE_BYTES; k++) begin
         issue(make_request(OP_APPEND, 1'($urandom_range(0, 1)), 0, 0, 1'b0, 0), 1'b0, '0);
         issue(make_request(OP_SET_LENGTH, 1'b0, 0, 0, 1'b0, MAX_BITS), 1'b0, '0);
      end
      for (k = 0; k < 3; k++)
         issue(make_request(OP_APPEND, 1'($urandom_range(0, 1)), 0, 0, 1'b0, 0), 1'b0, '0);
      // scatter bits over the top end before reading it back
      for (k = 0; k < 24; k++)
         issue(make_request(OP_SET_BIT, 1'($urandom_range(0, 1)),
                            $urandom_range(MAX_BITS - 48, MAX_BITS - 1), 0, 1'b0, 0),
               1'b0, '0);
      issue(make_request(OP_GET_BIT, 1'b0, MAX_BITS, 0, 1'b0, 0), 1'b0, '0);
      issue(make_request(OP_GET_BIT, 1'b0, MAX_BITS - 1, 0, 1'b0, 0), 1'b0, '0);
      issue(make_request(OP_GET_RANGE, 1'b0, MAX_BITS - 32, MAX_BITS, 1'b1, 0), 1'b0, '0);
      issue(make_request(OP_GET_RANGE, 1'b0, 4000, MAX_BITS, 1'b0, 0), 1'b0, '0);
      issue(make_request(OP_GET_RANGE, 1'b0, 4000, MAX_BITS, 1'b1, 0), 1'b0, '0);
      issue(make_request(OP_SET_BIT, 1'b1, MAX_BITS, 0, 1'b0, 0), 1'b0, '0);
      issue(make_request(OP_SET_LENGTH, 1'b0, 0, 0, 1'b0, MAX_BITS), 1'b0, '0);
      issue(make_request(OP_SET_LENGTH, 1'b0, 0, 0, 1'b0, 4000), 1'b0, '0);
      issue(make_request(OP_APPEND, 1'b1, 0, 0, 1'b0, 0), 1'b0, '0);
      issue(make_request(OP_SET_BIT, 1'b0, 4000, 0, 1'b0, 0), 1'b0, '0);

      for (phase = 0; phase < 4; phase++) begin
         set_bit_order(phase[0]);
         tx_eager = (phase == 1 || phase == 3);
         rx_eager = (phase >= 2);
         issue(make_request(OP_CLEAR, 1'b0, 0, 0, 1'b0, 0), 1'b0, '0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // hold off until every result is back
            if (n == PHASE_ITEMS / 2) wait_idle();
            rq = random_request();
            issue(rq, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (due_results.size() != 0)
         report_mismatch("results still due at end, count", 32'(due_results.size()), '0);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
design/bba_pkg.sv
design/bba_store.sv
design/bba_merge.sv
design/bit_buffer_append_extract.sv
test/testbench.sv
